/* rtl/core/masked_histogram_binning_unit_defines.svh */
// Assertion helpers shared by the checker
`ifndef MASKED_HISTOGRAM_BINNING_UNIT_DEFINES_SVH
`define MASKED_HISTOGRAM_BINNING_UNIT_DEFINES_SVH
// Assert that a property holds while out of reset
`define MHB_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// Assert that a property holds at every rising clock edge
`define MHB_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`endif

/* rtl/core/mhb_pkg.sv */
`default_nettype none
package mhb_pkg;
    localparam int MAX_BINS_DEF = 64;

    typedef enum logic [1:0] {
        OP_ADD   = 2'd0,
        OP_BOUND = 2'd1,
        OP_READ  = 2'd2,
        OP_CLEAR = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        ST_BINNED = 3'd0,
        ST_BELOW  = 3'd1,
        ST_ABOVE  = 3'd2,
        ST_MASKED = 3'd3,
        ST_BOUND  = 3'd4,
        ST_READ   = 3'd5,
        ST_CLEAR  = 3'd6,
        ST_BADIDX = 3'd7
    } status_t;

    typedef enum logic [2:0] {
        REG_UNIFORM = 3'd0,
        REG_LOWER   = 3'd1,
        REG_WIDTH   = 3'd2,
        REG_BINS    = 3'd3,
        REG_MASK    = 3'd4
    } reg_idx_t;

    typedef enum logic [3:0] {
        S_IDLE, S_LO, S_HI, S_CMP_HI, S_DIV, S_SEARCH, S_SRCH_WAIT,
        S_CNT_RD, S_CNT_WAIT, S_CNT_WR, S_CLEAR, S_INIT, S_OUT
    } state_t;
endpackage
`default_nettype wire

/* rtl/core/masked_histogram_binning_unit.sv */
`default_nettype none
// Flow, accept to result valid: an in-range uniform add uses the 33-step divider;
// an in-range table add runs a binary search of the boundary table; a read fetches
// its count; an out-of-range add stops at the range tests; masked add, bound write
// and bad index go straight to the result; clear sweeps all MAX_BINS counts to zero.
// Throughput: one transaction at a time; s_ready is low until the result is taken.
// Reset (aresetn, synchronous): registers to defaults, counts swept to zero.
module masked_histogram_binning_unit #(
    parameter int MAX_BINS = mhb_pkg::MAX_BINS_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [1:0]  s_op,
    input  wire logic [31:0] s_value,
    input  wire logic [7:0]  s_mask_bits,
    input  wire logic [6:0]  s_index,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [5:0]       m_bin_index,
    output logic [31:0]      m_bin_count,
    output logic [31:0]      m_below_count,
    output logic [31:0]      m_above_count,
    output logic [2:0]       m_status,
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [31:0] cfg_data
);
    localparam int BW  = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;
    localparam int TW  = $clog2(MAX_BINS + 1);
    localparam int NW  = TW;
    localparam int HW  = 40;

    // Configuration registers
    logic              uniform_reg;
    logic signed [31:0] lower_reg;
    logic [30:0]       width_reg;
    logic [6:0]        bins_reg;
    logic [7:0]        mask_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            uniform_reg <= 1'b1;
            lower_reg   <= '0;
            width_reg   <= 31'd65536;
            bins_reg    <= 7'd64;
            mask_reg    <= '0;
        end else if (cfg_we) begin
            case (mhb_pkg::reg_idx_t'(cfg_index))
                mhb_pkg::REG_UNIFORM: uniform_reg <= cfg_data[0];
                mhb_pkg::REG_LOWER:   lower_reg   <= cfg_data;
                mhb_pkg::REG_WIDTH:   width_reg   <= cfg_data[30:0];
                mhb_pkg::REG_BINS:    bins_reg    <= cfg_data[6:0];
                mhb_pkg::REG_MASK:    mask_reg    <= cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // Effective bin count and width
    logic [NW-1:0] n_eff;
    logic [30:0]   w_eff;
    always_comb begin
        if (bins_reg == 7'd0)
            n_eff = NW'(1);
        else if (32'(bins_reg) > 32'(MAX_BINS))
            n_eff = NW'(MAX_BINS);
        else
            n_eff = NW'(bins_reg);
        w_eff = (width_reg == 31'd0) ? 31'd1 : width_reg;
    end

    // Memories
    logic [31:0] cnt_mem [MAX_BINS];
    logic [31:0] bnd_mem [MAX_BINS+1];
    logic [31:0] cnt_rd_reg;
    logic [31:0] bnd_rd_reg;
    logic        cnt_we;
    logic [BW-1:0] cnt_waddr, cnt_raddr;
    logic [31:0] cnt_wdata;
    logic        bnd_we;
    logic [TW-1:0] bnd_waddr, bnd_raddr;

    always_ff @(posedge aclk) begin
        if (cnt_we) cnt_mem[cnt_waddr] <= cnt_wdata;
        cnt_rd_reg <= cnt_mem[cnt_raddr];
    end
    always_ff @(posedge aclk) begin
        if (bnd_we) bnd_mem[bnd_waddr] <= s_value;
        bnd_rd_reg <= bnd_mem[bnd_raddr];
    end

    // Sequencer state
    mhb_pkg::state_t state_reg, state_next;
    logic [1:0]  op_reg, op_next;
    logic signed [31:0] val_reg, val_next;
    logic signed [HW-1:0] lo_reg, lo_next, hi_reg, hi_next;
    logic [NW-1:0] sl_reg, sl_next, sh_reg, sh_next;
    logic [BW-1:0] bin_reg, bin_next;
    logic [TW-1:0] clr_reg, clr_next;
    logic [31:0] under_reg, under_next, over_reg, over_next;
    logic [5:0]  obi_reg, obi_next;
    logic [31:0] obc_reg, obc_next;
    logic [2:0]  ost_reg, ost_next;
    logic        div_start;
    logic        div_done;
    logic [NW-1:0] div_q;
    logic [NW-1:0] mid;
    logic [HW-1:0] prod;

    mhb_divider #(.QW(NW)) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (33'(val_reg) - 33'(lower_reg)),
        .divisor  (w_eff),
        .done     (div_done),
        .quotient (div_q)
    );

    assign mid  = NW'((32'(sl_reg) + 32'(sh_reg) + 32'd1) >> 1);
    assign prod = HW'(w_eff) * HW'(n_eff);

    always_comb begin
        state_next = state_reg;
        op_next    = op_reg;
        val_next   = val_reg;
        lo_next    = lo_reg;
        hi_next    = hi_reg;
        sl_next    = sl_reg;
        sh_next    = sh_reg;
        bin_next   = bin_reg;
        clr_next   = clr_reg;
        under_next = under_reg;
        over_next  = over_reg;
        obi_next   = obi_reg;
        obc_next   = obc_reg;
        ost_next   = ost_reg;
        div_start  = 1'b0;
        cnt_we     = 1'b0;
        cnt_waddr  = bin_reg;
        cnt_wdata  = '0;
        cnt_raddr  = bin_reg;
        bnd_we     = 1'b0;
        bnd_waddr  = TW'(s_index);
        bnd_raddr  = TW'(0);
        case (state_reg)
            mhb_pkg::S_IDLE: begin
                if (s_valid) begin
                    op_next  = s_op;
                    val_next = s_value;
                    obi_next = '0;
                    obc_next = '0;
                    case (mhb_pkg::op_t'(s_op))
                        mhb_pkg::OP_ADD: begin
                            if ((s_mask_bits & mask_reg) != 8'd0) begin
                                ost_next   = mhb_pkg::ST_MASKED;
                                state_next = mhb_pkg::S_OUT;
                            end else begin
                                state_next = mhb_pkg::S_LO;
                            end
                        end
                        mhb_pkg::OP_BOUND: begin
                            if (32'(s_index) > 32'(MAX_BINS)) begin
                                ost_next = mhb_pkg::ST_BADIDX;
                            end else begin
                                bnd_we   = 1'b1;
                                ost_next = mhb_pkg::ST_BOUND;
                            end
                            state_next = mhb_pkg::S_OUT;
                        end
                        mhb_pkg::OP_READ: begin
                            if (32'(s_index) >= 32'(n_eff)) begin
                                ost_next   = mhb_pkg::ST_BADIDX;
                                state_next = mhb_pkg::S_OUT;
                            end else begin
                                bin_next   = BW'(s_index);
                                state_next = mhb_pkg::S_CNT_RD;
                            end
                        end
                        default: begin
                            clr_next   = '0;
                            under_next = '0;
                            over_next  = '0;
                            state_next = mhb_pkg::S_CLEAR;
                        end
                    endcase
                end
            end
            // Fetch low edge: table entry 0 or lower register
            mhb_pkg::S_LO: begin
                bnd_raddr  = TW'(0);
                state_next = mhb_pkg::S_HI;
            end
            mhb_pkg::S_HI: begin
                bnd_raddr = TW'(n_eff);
                if (uniform_reg) begin
                    lo_next = HW'(lower_reg);
                    hi_next = HW'(lower_reg) + $signed(prod);
                end else begin
                    lo_next = HW'($signed(bnd_rd_reg));
                end
                state_next = mhb_pkg::S_CMP_HI;
            end
            mhb_pkg::S_CMP_HI: begin
                if (!uniform_reg) hi_next = HW'($signed(bnd_rd_reg));
                state_next = mhb_pkg::S_SEARCH;
                sl_next = '0;
                sh_next = n_eff - NW'(1);
            end
            // Range tests, then divide or search
            mhb_pkg::S_SEARCH: begin
                if (HW'(val_reg) < lo_reg) begin
                    under_next = (under_reg == '1) ? under_reg : under_reg + 32'd1;
                    ost_next   = mhb_pkg::ST_BELOW;
                    state_next = mhb_pkg::S_OUT;
                end else if (HW'(val_reg) > hi_reg) begin
                    over_next  = (over_reg == '1) ? over_reg : over_reg + 32'd1;
                    ost_next   = mhb_pkg::ST_ABOVE;
                    state_next = mhb_pkg::S_OUT;
                end else if (uniform_reg) begin
                    div_start  = 1'b1;
                    state_next = mhb_pkg::S_DIV;
                end else if (sl_reg < sh_reg) begin
                    bnd_raddr  = TW'(mid);
                    state_next = mhb_pkg::S_SRCH_WAIT;
                end else begin
                    bin_next   = BW'(sl_reg);
                    state_next = mhb_pkg::S_CNT_RD;
                end
            end
            // One binary search step per memory read
            mhb_pkg::S_SRCH_WAIT: begin
                if ($signed(bnd_rd_reg) <= val_reg)
                    sl_next = mid;
                else
                    sh_next = mid - NW'(1);
                state_next = mhb_pkg::S_SEARCH;
            end
            mhb_pkg::S_DIV: begin
                if (div_done) begin
                    bin_next = (div_q >= n_eff) ? BW'(n_eff - NW'(1)) : BW'(div_q);
                    state_next = mhb_pkg::S_CNT_RD;
                end
            end
            mhb_pkg::S_CNT_RD: begin
                cnt_raddr  = bin_reg;
                state_next = mhb_pkg::S_CNT_WAIT;
            end
            mhb_pkg::S_CNT_WAIT: begin
                state_next = mhb_pkg::S_CNT_WR;
            end
            mhb_pkg::S_CNT_WR: begin
                obi_next = 6'(bin_reg);
                if (op_reg == mhb_pkg::OP_ADD) begin
                    cnt_we    = 1'b1;
                    cnt_wdata = (cnt_rd_reg == '1) ? cnt_rd_reg : cnt_rd_reg + 32'd1;
                    obc_next  = cnt_wdata;
                    ost_next  = mhb_pkg::ST_BINNED;
                end else begin
                    obc_next  = cnt_rd_reg;
                    ost_next  = mhb_pkg::ST_READ;
                end
                state_next = mhb_pkg::S_OUT;
            end
            // Sweep counters to zero after reset or on a clear op
            mhb_pkg::S_INIT, mhb_pkg::S_CLEAR: begin
                cnt_we    = 1'b1;
                cnt_waddr = BW'(clr_reg);
                cnt_wdata = '0;
                clr_next  = clr_reg + TW'(1);
                if (32'(clr_reg) == 32'(MAX_BINS - 1)) begin
                    if (state_reg == mhb_pkg::S_CLEAR) begin
                        ost_next   = mhb_pkg::ST_CLEAR;
                        state_next = mhb_pkg::S_OUT;
                    end else begin
                        state_next = mhb_pkg::S_IDLE;
                    end
                end
            end
            mhb_pkg::S_OUT: begin
                if (m_ready) state_next = mhb_pkg::S_IDLE;
            end
            default: state_next = mhb_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        op_reg  <= op_next;
        val_reg <= val_next;
        lo_reg  <= lo_next;
        hi_reg  <= hi_next;
        sl_reg  <= sl_next;
        sh_reg  <= sh_next;
        bin_reg <= bin_next;
        obi_reg <= obi_next;
        obc_reg <= obc_next;
        ost_reg <= ost_next;
        if (!aresetn) begin
            state_reg <= mhb_pkg::S_INIT;
            clr_reg   <= '0;
            under_reg <= '0;
            over_reg  <= '0;
        end else begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            under_reg <= under_next;
            over_reg  <= over_next;
        end
    end

    assign s_ready       = (state_reg == mhb_pkg::S_IDLE);
    assign m_valid       = (state_reg == mhb_pkg::S_OUT);
    assign m_bin_index   = obi_reg;
    assign m_bin_count   = obc_reg;
    assign m_below_count = under_reg;
    assign m_above_count = over_reg;
    assign m_status      = ost_reg;
endmodule
`default_nettype wire

/* rtl/core/mhb_divider.sv */
`default_nettype none
// Restoring divider: one quotient bit per cycle, quotient saturates to QW bits
module mhb_divider #(
    parameter int QW = 7
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          start,
    input  wire logic [32:0]   dividend,
    input  wire logic [30:0]   divisor,
    output logic               done,
    output logic [QW-1:0]      quotient
);
    localparam int STEPS = 33;
    logic [32:0] rem_reg, rem_next;
    logic [32:0] dvd_reg, dvd_next;
    logic [33:0] quo_reg, quo_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [33:0] trial;

    // One shift and subtract per cycle
    always_comb begin
        rem_next  = rem_reg;
        dvd_next  = dvd_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {rem_reg, dvd_reg[32]} - {3'b0, divisor};
        if (start) begin
            rem_next  = '0;
            dvd_next  = dividend;
            quo_next  = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            dvd_next = {dvd_reg[31:0], 1'b0};
            if (!trial[33]) begin
                rem_next = trial[32:0];
                quo_next = {quo_reg[32:0], 1'b1};
            end else begin
                rem_next = {rem_reg[31:0], dvd_reg[32]};
                quo_next = {quo_reg[32:0], 1'b0};
            end
            cnt_next = cnt_reg + 6'd1;
            if (cnt_reg == 6'(STEPS - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        dvd_reg <= dvd_next;
        quo_reg <= quo_next;
        cnt_reg <= cnt_next;
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    assign done     = done_reg;
    assign quotient = (quo_reg > 34'((1 << QW) - 1)) ? {QW{1'b1}} : quo_reg[QW-1:0];
endmodule
`default_nettype wire

/* rtl/core/mhb_checker.sv */
`default_nettype none
`include "masked_histogram_binning_unit_defines.svh"
// Port-level checks on the histogram unit
module mhb_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_valid,
    input wire logic        s_ready,
    input wire logic        m_valid,
    input wire logic        m_ready,
    input wire logic [2:0]  m_status,
    input wire logic [5:0]  m_bin_index,
    input wire logic [31:0] m_bin_count
);
    // Never take input while a result waits
    `MHB_ASSERT(a_no_overlap, aclk, aresetn, !(s_ready && m_valid), "ready while result pending")
    // Result stays until taken
    `MHB_ASSERT(a_hold, aclk, aresetn, (m_valid && !m_ready) |=> m_valid, "result dropped")
    // Accepted transaction leaves the unit busy
    `MHB_ASSERT(a_busy, aclk, aresetn, (s_valid && s_ready) |=> !s_ready, "ready after accept")
    // Binned result always carries a nonzero count
    `MHB_ASSERT(a_count, aclk, aresetn, (m_valid && m_status == mhb_pkg::ST_BINNED) |-> (m_bin_count != 32'd0), "binned with zero count")
    // Results without a bin carry zero index and count
    `MHB_ASSERT(a_no_bin, aclk, aresetn, (m_valid && m_status != mhb_pkg::ST_BINNED && m_status != mhb_pkg::ST_READ) |-> (m_bin_index == 6'd0 && m_bin_count == 32'd0), "bin fields set without a bin")
endmodule

bind masked_histogram_binning_unit mhb_checker u_mhb_checker (
    .aclk        (aclk),
    .aresetn     (aresetn),
    .s_valid     (s_valid),
    .s_ready     (s_ready),
    .m_valid     (m_valid),
    .m_ready     (m_ready),
    .m_status    (m_status),
    .m_bin_index (m_bin_index),
    .m_bin_count (m_bin_count)
);
`default_nettype wire
